// ===== hw/rtl/rdsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsr_pkg
// Shared sizes, types and helpers of the rrip/dip/ship replacement unit.
// ----------------------------------------------------------------------------
package rdsr_pkg;

	localparam int NUM_SETS    = 2048;
	localparam int NUM_WAYS    = 16;
	localparam int LEADER_SETS = 32;
	localparam int PSEL_BITS   = 10;
	localparam int SIG_BITS    = 4;

	localparam int SET_W     = $clog2(NUM_SETS);
	localparam int WAY_W     = $clog2(NUM_WAYS);
	localparam int SIG_COUNT = 1 << SIG_BITS;
	localparam int ADDR_W    = 64;
	localparam int AGE_W     = 2;
	localparam int CNT_W     = 2;
	localparam int BIP_W     = 5;
	localparam int MASK_W    = 16;
	localparam int SET_IN_W  = 11;
	localparam int WAY_IN_W  = 4;
	localparam int CLR_LEN   = (NUM_SETS > SIG_COUNT) ? NUM_SETS : SIG_COUNT;
	localparam int CLR_W     = $clog2(CLR_LEN);

	localparam logic [AGE_W-1:0]     AGE_MAX   = 2'd3;
	localparam logic [AGE_W-1:0]     AGE_NEAR  = 2'd1;
	localparam logic [CNT_W-1:0]     CNT_MAX   = 2'd3;
	localparam logic [CNT_W-1:0]     CNT_HOT   = 2'd2;
	localparam logic [PSEL_BITS-1:0] PSEL_MID  = PSEL_BITS'(1 << (PSEL_BITS - 1));
	localparam logic [PSEL_BITS-1:0] PSEL_MAX  = '1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROW,
		ST_REUSE
	} state_t;

	typedef enum logic {
		OP_VICTIM = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	// one memory row holds every way of a set
	typedef struct packed {
		logic [NUM_WAYS-1:0][AGE_W-1:0]    age;
		logic [NUM_WAYS-1:0][SIG_BITS-1:0] sig;
		logic [NUM_WAYS-1:0]               strm;
		logic [NUM_WAYS-1:0][ADDR_W-1:0]   last;
	} row_t;

	// input tdata layout, lowest field last
	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] victim_address;
		logic [ADDR_W-1:0] paddr;
		logic [ADDR_W-1:0] pc;
		logic [MASK_W-1:0] valid_mask;
		logic [WAY_IN_W-1:0] way_index;
		logic [SET_IN_W-1:0] set_index;
	} req_t;

	typedef struct packed {
		logic             chose_lip;
		logic             marked_streaming;
		logic [AGE_W-1:0] inserted_age;
		logic [3:0]       victim_way;
	} res_t;

	typedef struct packed {
		logic             re;
		logic [SET_W-1:0] raddr;
		logic             we;
		logic [SET_W-1:0] waddr;
		row_t             wdata;
	} row_req_t;

	typedef struct packed {
		logic                re0;
		logic [SIG_BITS-1:0] raddr0;
		logic                re1;
		logic [SIG_BITS-1:0] raddr1;
		logic                we;
		logic [SIG_BITS-1:0] waddr;
		logic [CNT_W-1:0]    wdata;
	} reuse_req_t;

	function automatic logic [SIG_BITS-1:0] sig_hash(input logic [ADDR_W-1:0] pc);
		logic [ADDR_W-1:0] mix;
		mix = pc ^ (pc >> 4) ^ (pc >> 8);
		return mix[SIG_BITS-1:0];
	endfunction

endpackage

// ===== hw/rtl/rdsr_row_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsr_row_mem
// Per-set block state: one row per set, one write and one registered read.
// ----------------------------------------------------------------------------
module rdsr_row_mem (
	input  logic               clk,
	input  rdsr_pkg::row_req_t req,
	output rdsr_pkg::row_t     rdata
);

	rdsr_pkg::row_t mem [rdsr_pkg::NUM_SETS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== hw/rtl/rdsr_reuse_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsr_reuse_mem
// Saturating reuse counters per signature: two registered reads, one write.
// ----------------------------------------------------------------------------
module rdsr_reuse_mem (
	input  logic                           clk,
	input  rdsr_pkg::reuse_req_t           req,
	output logic [rdsr_pkg::CNT_W-1:0]     rdata0,
	output logic [rdsr_pkg::CNT_W-1:0]     rdata1
);

	logic [rdsr_pkg::CNT_W-1:0] mem [rdsr_pkg::SIG_COUNT];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re0) begin
			rdata0 <= mem[req.raddr0];
		end
		if (req.re1) begin
			rdata1 <= mem[req.raddr1];
		end
	end

endmodule

// ===== hw/rtl/rrip_dip_ship_replacement_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_dip_ship_replacement_unit
// Cache replacement engine: srrip aging, dip insertion, signature reuse bias.
//
// channel   direction  contents
// s_axis    in         tuser: opcode; tdata: set, way, mask, pc, paddr,
//                      victim address, hit
// m_axis    out        tdata: victim way, inserted age, streaming, chose lip
//
// a victim request or an update hit reads the set row, then modifies and
// writes it back (not for a victim request that finds an invalid way); a
// miss update also does a read-modify-write of the old signature's reuse
// counter. after reset a clearing pass writes zero to all rows and
// counters, with s_axis_tready low.
// a finished result waits in the output register and one more in a hold
// register; the input is accepted only while idle and the hold register is empty.
// ----------------------------------------------------------------------------
module rrip_dip_ship_replacement_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [10:0] set_index, [14:11] way_index, [30:15] valid_mask, [94:31] pc,
	// [158:95] paddr, [222:159] victim_address, [223] hit
	input  logic [223:0] s_axis_tdata,
	// [0] opcode
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [3:0] victim_way, [5:4] inserted_age, [6] marked_streaming, [7] chose_lip
	output logic [7:0]   m_axis_tdata
);

	localparam int NW = rdsr_pkg::NUM_WAYS;

	rdsr_pkg::state_t   state_q, state_d;
	logic [rdsr_pkg::CLR_W-1:0] clr_q;

	rdsr_pkg::req_t     req_in;
	rdsr_pkg::req_t     req_s1;
	rdsr_pkg::op_t      op_s1;
	logic [rdsr_pkg::SIG_BITS-1:0] sig_in, sig_s1;
	logic               accept;

	rdsr_pkg::row_req_t   row_req;
	rdsr_pkg::row_t       row_rd;
	rdsr_pkg::reuse_req_t reuse_req;
	logic [rdsr_pkg::CNT_W-1:0] reuse_rd0, reuse_rd1;

	logic [rdsr_pkg::PSEL_BITS-1:0] psel_q;
	logic [rdsr_pkg::BIP_W-1:0]     bip_q;

	// row stage results
	logic                         is_update, way_ok, miss_upd;
	logic [rdsr_pkg::WAY_W-1:0]   way;
	logic [rdsr_pkg::SET_W-1:0]   set_s1;
	logic                         lip_leader, bip_leader, use_lip, streaming;
	logic [rdsr_pkg::SIG_BITS-1:0] old_sig;
	logic [rdsr_pkg::AGE_W-1:0]   upd_age;
	logic                         found_inv;
	logic [NW-1:0][rdsr_pkg::AGE_W-1:0] aged;
	logic [rdsr_pkg::WAY_W-1:0]   pick_way;
	rdsr_pkg::row_t               row_wd;
	rdsr_pkg::res_t               res_row;

	logic [rdsr_pkg::SIG_BITS-1:0] old_sig_s2;
	rdsr_pkg::res_t               res_s2;

	logic                         finish;
	rdsr_pkg::res_t               fin_res;
	logic                         out_valid_q, hold_valid_q, out_free;
	rdsr_pkg::res_t               out_q, hold_q;

	assign req_in = rdsr_pkg::req_t'(s_axis_tdata);
	assign sig_in = rdsr_pkg::sig_hash(req_in.pc);
	assign accept = s_axis_tvalid & s_axis_tready;

	rdsr_row_mem u_row_mem (
		.clk   (clk),
		.req   (row_req),
		.rdata (row_rd)
	);

	rdsr_reuse_mem u_reuse_mem (
		.clk    (clk),
		.req    (reuse_req),
		.rdata0 (reuse_rd0),
		.rdata1 (reuse_rd1)
	);

	// victim choice and update decisions from the row read
	always_comb begin
		logic [NW-1:0] valid_ext;
		logic [rdsr_pkg::WAY_W-1:0] inv_way, old_way;
		logic any3, any2, any1;
		logic [rdsr_pkg::AGE_W-1:0] add;
		logic [rdsr_pkg::ADDR_W-1:0] last, stride;

		is_update = (op_s1 == rdsr_pkg::OP_UPDATE);
		set_s1    = req_s1.set_index[rdsr_pkg::SET_W-1:0];
		way       = rdsr_pkg::WAY_W'(req_s1.way_index);
		way_ok    = 32'(req_s1.way_index) < NW;
		miss_upd  = is_update && way_ok && !req_s1.hit;

		for (int w = 0; w < NW; w++) begin
			valid_ext[w] = (w < rdsr_pkg::MASK_W) ?
				req_s1.valid_mask[w % rdsr_pkg::MASK_W] : 1'b1;
		end
		found_inv = ~&valid_ext;
		inv_way   = '0;
		for (int w = NW - 1; w >= 0; w--) begin
			if (!valid_ext[w]) inv_way = rdsr_pkg::WAY_W'(w);
		end

		any3 = 1'b0;
		any2 = 1'b0;
		any1 = 1'b0;
		for (int w = 0; w < NW; w++) begin
			any3 = any3 | (row_rd.age[w] == 2'd3);
			any2 = any2 | (row_rd.age[w] == 2'd2);
			any1 = any1 | (row_rd.age[w] == 2'd1);
		end
		if (any3) add = 2'd0;
		else if (any2) add = 2'd1;
		else if (any1) add = 2'd2;
		else add = 2'd3;
		for (int w = 0; w < NW; w++) begin
			aged[w] = row_rd.age[w] + add;
		end
		old_way = '0;
		for (int w = NW - 1; w >= 0; w--) begin
			if (aged[w] == rdsr_pkg::AGE_MAX) old_way = rdsr_pkg::WAY_W'(w);
		end
		pick_way = found_inv ? inv_way : old_way;

		// stride check against the block's last address
		last      = row_rd.last[way];
		stride    = (last != '0) ? (req_s1.paddr - last) : '0;
		streaming = (stride != '0) && (stride == (last - req_s1.victim_address));

		lip_leader = 32'(set_s1) < (rdsr_pkg::LEADER_SETS / 2);
		bip_leader = !lip_leader && (32'(set_s1) < rdsr_pkg::LEADER_SETS);
		if (lip_leader) use_lip = 1'b1;
		else if (bip_leader) use_lip = 1'b0;
		else use_lip = (psel_q >= rdsr_pkg::PSEL_MID);

		old_sig = row_rd.sig[way];

		if (req_s1.hit) begin
			upd_age = '0;
		end else if (streaming) begin
			upd_age = rdsr_pkg::AGE_MAX;
		end else begin
			upd_age = rdsr_pkg::AGE_MAX;
			if (!use_lip) upd_age = (bip_q == '0) ? '0 : rdsr_pkg::AGE_MAX;
			if (reuse_rd0 >= rdsr_pkg::CNT_HOT) upd_age = rdsr_pkg::AGE_NEAR;
		end

		row_wd = row_rd;
		if (is_update) begin
			row_wd.age[way]  = upd_age;
			row_wd.sig[way]  = sig_s1;
			row_wd.strm[way] = !req_s1.hit && streaming;
			row_wd.last[way] = req_s1.paddr;
		end else begin
			row_wd.age = aged;
		end

		res_row = '0;
		if (!is_update) begin
			res_row.victim_way = 4'(pick_way);
		end else if (way_ok) begin
			res_row.inserted_age     = upd_age;
			res_row.marked_streaming = !req_s1.hit && streaming;
			res_row.chose_lip        = use_lip;
		end
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rdsr_pkg::ST_CLEAR: begin
				if (clr_q == rdsr_pkg::CLR_W'(rdsr_pkg::CLR_LEN - 1)) state_d = rdsr_pkg::ST_IDLE;
			end
			rdsr_pkg::ST_IDLE: begin
				if (accept) state_d = rdsr_pkg::ST_ROW;
			end
			rdsr_pkg::ST_ROW: begin
				state_d = miss_upd ? rdsr_pkg::ST_REUSE : rdsr_pkg::ST_IDLE;
			end
			rdsr_pkg::ST_REUSE: begin
				state_d = rdsr_pkg::ST_IDLE;
			end
			default: begin
				state_d = rdsr_pkg::ST_CLEAR;
			end
		endcase
	end

	// sequencer: memory requests and completion
	always_comb begin
		row_req        = '0;
		reuse_req      = '0;
		finish         = 1'b0;
		fin_res        = res_row;
		s_axis_tready  = 1'b0;
		row_req.raddr    = req_in.set_index[rdsr_pkg::SET_W-1:0];
		reuse_req.raddr0 = sig_in;
		reuse_req.raddr1 = old_sig;
		case (state_q)
			rdsr_pkg::ST_CLEAR: begin
				row_req.we      = 1'b1;
				row_req.waddr   = clr_q[rdsr_pkg::SET_W-1:0];
				reuse_req.we    = 1'b1;
				reuse_req.waddr = clr_q[rdsr_pkg::SIG_BITS-1:0];
			end
			rdsr_pkg::ST_IDLE: begin
				s_axis_tready = !hold_valid_q;
				row_req.re    = accept;
				reuse_req.re0 = accept;
			end
			rdsr_pkg::ST_ROW: begin
				row_req.we    = (is_update && way_ok) || (!is_update && !found_inv);
				row_req.waddr = set_s1;
				row_req.wdata = row_wd;
				if (is_update && way_ok && req_s1.hit) begin
					reuse_req.we    = 1'b1;
					reuse_req.waddr = sig_s1;
					reuse_req.wdata = (reuse_rd0 == rdsr_pkg::CNT_MAX) ?
						reuse_rd0 : reuse_rd0 + 2'd1;
				end
				reuse_req.re1 = miss_upd;
				finish        = !miss_upd;
			end
			rdsr_pkg::ST_REUSE: begin
				// decay the counter of the signature the block carried before
				reuse_req.we    = 1'b1;
				reuse_req.waddr = old_sig_s2;
				reuse_req.wdata = (reuse_rd1 == '0) ? reuse_rd1 : reuse_rd1 - 2'd1;
				finish          = 1'b1;
				fin_res         = res_s2;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdsr_pkg::ST_CLEAR;
			clr_q   <= '0;
			psel_q  <= rdsr_pkg::PSEL_MID;
			bip_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rdsr_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == rdsr_pkg::ST_ROW && is_update && way_ok) begin
				if (req_s1.hit) begin
					if (lip_leader && psel_q != rdsr_pkg::PSEL_MAX) psel_q <= psel_q + 1'b1;
					if (bip_leader && psel_q != '0) psel_q <= psel_q - 1'b1;
				end else if (!streaming && !use_lip) begin
					bip_q <= bip_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_in;
			op_s1  <= rdsr_pkg::op_t'(s_axis_tuser[0]);
			sig_s1 <= sig_in;
		end
		if (state_q == rdsr_pkg::ST_ROW) begin
			old_sig_s2 <= old_sig;
			res_s2     <= res_row;
		end
	end

	// output register plus one hold entry
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= hold_valid_q || finish;
			hold_valid_q <= 1'b0;
		end else if (finish) begin
			hold_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= hold_valid_q ? hold_q : fin_res;
		end else if (finish) begin
			hold_q <= fin_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule
